### src/class_wise_box_suppression_assert.svh
// Assertion macros shared by the suppression block.
`ifndef CLASS_WISE_BOX_SUPPRESSION_ASSERT_SVH
`define CLASS_WISE_BOX_SUPPRESSION_ASSERT_SVH

`define CWBS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define CWBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/cwbs_pkg.sv
package cwbs_pkg;

   localparam int COORD_W = 15;
   localparam int EDGE_W  = 16;
   localparam int PIX_W   = 12;

   localparam logic [1:0] STATUS_KEPT       = 2'd0;
   localparam logic [1:0] STATUS_SUPPRESSED = 2'd1;
   localparam logic [1:0] STATUS_DROPPED    = 2'd2;

   localparam logic [1:0] CSR_IOU_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd2;

   typedef struct packed {
      logic                      first;
      logic signed [EDGE_W-1:0]  x0;
      logic signed [EDGE_W-1:0]  y0;
      logic signed [EDGE_W-1:0]  x1;
      logic signed [EDGE_W-1:0]  y1;
      logic [7:0]                cls;
      logic [15:0]               score;
   } box_type;

endpackage

### src/cwbs_ram.sv
module cwbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/cwbs_front.sv
module cwbs_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_first_of_frame,
   input  logic signed [14:0]            req_box_x,
   input  logic signed [14:0]            req_box_y,
   input  logic [13:0]                   req_box_w,
   input  logic [13:0]                   req_box_h,
   input  logic [7:0]                    req_class_id,
   input  logic [15:0]                   req_score,
   output logic                          q_valid,
   input  logic                          q_pop,
   output cwbs_pkg::box_type             q_box
);
   import cwbs_pkg::*;

   box_type  buf_ff [2];
   logic     wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   box_type  nb;
   logic     push;

   always_comb begin
      nb.first = req_first_of_frame;
      nb.x0 = EDGE_W'(req_box_x);
      nb.y0 = EDGE_W'(req_box_y);
      nb.x1 = EDGE_W'(req_box_x) + $signed({2'b00, req_box_w});
      nb.y1 = EDGE_W'(req_box_y) + $signed({2'b00, req_box_h});
      nb.cls = req_class_id;
      nb.score = req_score;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_box = buf_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= nb;
      end
   end
endmodule

### src/cwbs_back.sv
module cwbs_back #(
   parameter int MAX_KEPT  = 64,
   parameter int FRAC_BITS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  cwbs_pkg::box_type q_box,
   input  logic [15:0]       iou_threshold,
   input  logic [11:0]       image_width,
   input  logic [11:0]       image_height,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_slot,
   output logic [11:0]       rsp_left,
   output logic [11:0]       rsp_top,
   output logic [11:0]       rsp_right,
   output logic [11:0]       rsp_bottom,
   output logic [7:0]        rsp_out_class,
   output logic [15:0]       rsp_out_score
);
   import cwbs_pkg::*;
`include "class_wise_box_suppression_assert.svh"

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int ENT_W = 4 * EDGE_W + 8;
   localparam logic signed [17:0] ONE_PIX = 18'sd1 <<< FRAC_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_EXT  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_UNI  = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]    state_ff, state_in;
   box_type       box_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lim_ff;
   logic [1:0]    stat_ff;

   logic              wr_en;
   logic [ENT_W-1:0]  rd_data;
   logic [AW-1:0]     rd_addr;

   logic signed [EDGE_W-1:0] kx0, ky0, kx1, ky1;
   logic [7:0]               kcls;
   logic signed [17:0] iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic [35:0] inter_ff, area_a_ff, area_b_ff;
   logic [37:0] uni_ff;
   logic        same_ff;
   logic [53:0] lhs, rhs;

   logic        out_valid_ff;
   logic [1:0]  o_status_ff;
   logic [7:0]  o_slot_ff, o_class_ff;
   logic [11:0] o_l_ff, o_t_ff, o_r_ff, o_b_ff;
   logic [15:0] o_score_ff;

   cwbs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_KEPT)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data({box_ff.x0, box_ff.y0, box_ff.x1, box_ff.y1, box_ff.cls}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign {kx0, ky0, kx1, ky1, kcls} = rd_data;
   assign rd_addr = idx_ff[AW-1:0];

   function automatic logic signed [17:0] smin(logic signed [EDGE_W-1:0] a,
                                                logic signed [EDGE_W-1:0] b);
      return (a < b) ? 18'(a) : 18'(b);
   endfunction

   function automatic logic signed [17:0] smax(logic signed [EDGE_W-1:0] a,
                                                logic signed [EDGE_W-1:0] b);
      return (a > b) ? 18'(a) : 18'(b);
   endfunction

   function automatic logic [11:0] to_pix(logic signed [EDGE_W-1:0] v,
                                          logic [11:0] lim);
      logic [EDGE_W-1:0] p;
      p = EDGE_W'($unsigned(v) >> FRAC_BITS);
      if (v <= 0) begin
         return 12'd0;
      end
      return (p > EDGE_W'(lim)) ? lim : p[11:0];
   endfunction

   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign wr_en = (state_ff == ST_DONE) && (stat_ff == STATUS_KEPT) && !out_valid_ff;
   assign lhs = {2'b00, inter_ff, 16'h0};
   assign rhs = 54'(iou_threshold) * 54'(uni_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_READ;
               idx_in = '0;
               if (q_box.first) begin
                  count_in = '0;
               end
            end
         end
         ST_READ: begin
            if (count_ff == CW'(MAX_KEPT) || idx_ff == lim_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_EXT;
            end
         end
         ST_EXT: state_in = ST_MUL;
         ST_MUL: state_in = ST_UNI;
         ST_UNI: state_in = ST_CMP;
         ST_CMP: begin
            if (same_ff && uni_ff != '0 && lhs > rhs) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff) begin
               state_in = ST_IDLE;
               if (stat_ff == STATUS_KEPT) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_DONE && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end
      end

      if (q_pop) begin
         box_ff <= q_box;
         lim_ff <= q_box.first ? '0 : count_ff;
         stat_ff <= STATUS_KEPT;
      end
      if (state_ff == ST_READ && count_ff == CW'(MAX_KEPT)) begin
         stat_ff <= STATUS_DROPPED;
      end
      if (state_ff == ST_CMP && same_ff && uni_ff != '0 && lhs > rhs) begin
         stat_ff <= STATUS_SUPPRESSED;
      end
      if (state_ff == ST_EXT) begin
         iw_ff <= smin(kx1, box_ff.x1) - smax(kx0, box_ff.x0) + ONE_PIX;
         ih_ff <= smin(ky1, box_ff.y1) - smax(ky0, box_ff.y0) + ONE_PIX;
         aw_ff <= 18'(kx1) - 18'(kx0) + ONE_PIX;
         ah_ff <= 18'(ky1) - 18'(ky0) + ONE_PIX;
         bw_ff <= 18'(box_ff.x1) - 18'(box_ff.x0) + ONE_PIX;
         bh_ff <= 18'(box_ff.y1) - 18'(box_ff.y0) + ONE_PIX;
         same_ff <= (kcls == box_ff.cls);
      end
      if (state_ff == ST_MUL) begin
         inter_ff <= (iw_ff[17] || ih_ff[17]) ? 36'd0 :
                     36'(iw_ff[16:0]) * 36'(ih_ff[16:0]);
         area_a_ff <= 36'(aw_ff[16:0]) * 36'(ah_ff[16:0]);
         area_b_ff <= 36'(bw_ff[16:0]) * 36'(bh_ff[16:0]);
      end
      if (state_ff == ST_UNI) begin
         uni_ff <= 38'(area_a_ff) + 38'(area_b_ff) - 38'(inter_ff);
      end
      if (state_ff == ST_DONE && !out_valid_ff) begin
         o_status_ff <= stat_ff;
         o_class_ff <= box_ff.cls;
         o_score_ff <= box_ff.score;
         if (stat_ff == STATUS_KEPT) begin
            o_slot_ff <= 8'(count_ff);
            o_l_ff <= to_pix(box_ff.x0, image_width);
            o_t_ff <= to_pix(box_ff.y0, image_height);
            o_r_ff <= to_pix(box_ff.x1, image_width);
            o_b_ff <= to_pix(box_ff.y1, image_height);
         end else begin
            o_slot_ff <= '0;
            o_l_ff <= '0;
            o_t_ff <= '0;
            o_r_ff <= '0;
            o_b_ff <= '0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_status = o_status_ff;
   assign rsp_slot = o_slot_ff;
   assign rsp_left = o_l_ff;
   assign rsp_top = o_t_ff;
   assign rsp_right = o_r_ff;
   assign rsp_bottom = o_b_ff;
   assign rsp_out_class = o_class_ff;
   assign rsp_out_score = o_score_ff;

   `CWBS_ASSERT_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CW'(MAX_KEPT),
      "kept count exceeds cap")
   `CWBS_ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == ST_EXT, idx_ff < lim_ff,
      "scan past kept entries")
   `CWBS_ASSERT_NEXT(a_write_grows, clock, reset, wr_en, count_ff == $past(count_ff) + 1'b1,
      "kept write without count step")
endmodule

### src/class_wise_box_suppression.sv
// Class-wise greedy NMS: boxes arrive in falling score order and each gives one result.
// A box is compared with the kept boxes of the frame one at a time through a shared
// overlap unit reading the kept table memory, each comparison passing the states READ,
// EXT, MUL, UNI and CMP; the DONE state then registers the result. The back end works on
// one box at a time and pops the next only on return to IDLE; a suppressed box stops at
// its first overlap. A two-entry queue takes new boxes while the back end works. Once
// MAX_KEPT boxes (64 by default) are kept, status 2 is given without any comparison.
module class_wise_box_suppression #(
   parameter int MAX_KEPT  = 64,
   parameter int FRAC_BITS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_first_of_frame,
   input  logic signed [14:0] req_box_x,
   input  logic signed [14:0] req_box_y,
   input  logic [13:0]        req_box_w,
   input  logic [13:0]        req_box_h,
   input  logic [7:0]         req_class_id,
   input  logic [15:0]        req_score,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_slot,
   output logic [11:0]        rsp_left,
   output logic [11:0]        rsp_top,
   output logic [11:0]        rsp_right,
   output logic [11:0]        rsp_bottom,
   output logic [7:0]         rsp_out_class,
   output logic [15:0]        rsp_out_score,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import cwbs_pkg::*;

   logic [15:0] thr_ff;
   logic [11:0] wid_ff, hgt_ff;
   logic        q_valid, q_pop;
   box_type     q_box;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd29491;
         wid_ff <= 12'd640;
         hgt_ff <= 12'd640;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IOU_THRESHOLD: thr_ff <= csr_data;
            CSR_IMAGE_WIDTH:   wid_ff <= csr_data[11:0];
            CSR_IMAGE_HEIGHT:  hgt_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   cwbs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_first_of_frame, .req_box_x,
      .req_box_y, .req_box_w, .req_box_h, .req_class_id, .req_score,
      .q_valid, .q_pop, .q_box);

   cwbs_back #(.MAX_KEPT(MAX_KEPT), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_box,
      .iou_threshold(thr_ff), .image_width(wid_ff), .image_height(hgt_ff),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_slot, .rsp_left, .rsp_top,
      .rsp_right, .rsp_bottom, .rsp_out_class, .rsp_out_score);
endmodule
